[src/fpe_pkg.sv]
// ============================================================================
// fpe_pkg - shared definitions for the format print engine
// Character codes, parse mode, specifier and state encodings, the
// divide-by-ten reciprocal and the hex digit character function.
// ============================================================================
package fpe_pkg;

    // Width of the argument bits that take part in conversion.
    localparam int ARG_WIDTH = 32;

    // Depth of the digit store: enough for ten decimal digits.
    localparam int DIGIT_DEPTH = 10;
    localparam int COUNT_W     = $clog2(DIGIT_DEPTH + 1);

    // Reciprocal of ten, scaled by 2^(ARG_WIDTH+3) and rounded up. It gives an
    // exact quotient for every ARG_WIDTH-bit value.
    localparam int DIV10_SHIFT = ARG_WIDTH + 3;
    localparam logic [ARG_WIDTH-1:0] DIV10_RECIP =
        ARG_WIDTH'(((64'd1 << DIV10_SHIFT) + 64'd9) / 64'd10);

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_QM    = 8'h3F;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_LC_D  = 8'h64;
    localparam logic [7:0] CHAR_LC_U  = 8'h75;
    localparam logic [7:0] CHAR_LC_X  = 8'h78;
    localparam logic [7:0] CHAR_UC_X  = 8'h58;
    localparam logic [7:0] CHAR_LC_C  = 8'h63;
    localparam logic [7:0] CHAR_LC_S  = 8'h73;

    localparam logic REQ_FMT = 1'b0;
    localparam logic REQ_ARG = 1'b1;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_PCT   = 2'd1,
        MODE_ARG   = 2'd2
    } parse_mode_t;

    typedef enum logic [1:0] {
        SPEC_D = 2'd0,
        SPEC_U = 2'd1,
        SPEC_X = 2'd2,
        SPEC_C = 2'd3
    } spec_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CHAR = 6'b000010,
        S_SIGN = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIG  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    // Lower-case hex digit character for a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
        begin
            ch = 8'h30 + {4'd0, nib};
        end
        else
        begin
            ch = 8'h57 + {4'd0, nib};
        end
        return ch;
    endfunction

endpackage

[src/format_print_engine.sv]
// ============================================================================
// format_print_engine - minimal printf-style integer formatter
// Turns a stream of format characters and argument words into output text.
// ============================================================================
// A user's summary: each input transaction is either a format character
// (tuser low) or an argument word (tuser high). Plain characters are echoed,
// a newline going out as carriage return then newline. After '%', the
// specifiers d, u, x/X and c wait for the next argument word, which is printed
// as signed decimal, unsigned decimal, lower-case hex or a single character;
// "%%" prints '%', "%s" prints nothing and any other specifier prints '?'.
// Items arriving out of turn are dropped silently. The block handles one item
// at a time and holds s_tready low while it works. A plain character is
// accepted, then emitted. A number is accepted, a '-' sign is emitted when
// the value is negative, each digit passes through the shared digit unit (in
// decimal a registered reciprocal multiply, then the remainder), and the
// digits are then emitted. Emission waits while the output register is still
// held by m_tready. One master-side transaction is issued per cycle at most
// and the output register lets the next item be accepted while the final
// character of the previous one still awaits m_tready.
// ============================================================================
module format_print_engine
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] fmt_char, [39:8] arg_word
    input  logic [0:0]  s_tuser,   // [0] req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast    // last_char
);
    import fpe_pkg::*;

    state_t               state_reg, state_next;
    parse_mode_t          mode_reg, mode_next;
    spec_t                spec_reg, spec_next;
    logic [ARG_WIDTH-1:0] work_reg, work_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [7:0]           char_reg, char_next;
    logic                 pre_reg, pre_next;

    // The digit store holds digit characters, least significant first.
    logic [7:0]           digit_store [DIGIT_DEPTH];

    logic                 m_valid_reg;
    logic [7:0]           m_data_reg;
    logic                 m_last_reg;

    logic                 accept;
    logic                 out_free;
    logic                 emit;
    logic [7:0]           emit_char;
    logic                 emit_last;
    logic                 unit_load;
    logic                 digit_wr;
    logic [ARG_WIDTH-1:0] unit_quot;
    logic [7:0]           unit_char;

    logic [7:0]           in_char;
    logic [ARG_WIDTH-1:0] in_arg;
    logic                 in_req;

    assign in_char  = s_tdata[7:0];
    assign in_arg   = s_tdata[8 +: ARG_WIDTH];
    assign in_req   = s_tuser[0];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    fpe_digit_unit u_digit
    (
        .clk        (clk),
        .load       (unit_load),
        .hex        (spec_reg == SPEC_X),
        .value      (work_reg),
        .quot       (unit_quot),
        .digit_char (unit_char)
    );

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        spec_next  = spec_reg;
        work_next  = work_reg;
        count_next = count_reg;
        char_next  = char_reg;
        pre_next   = pre_reg;
        emit       = 1'b0;
        emit_char  = char_reg;
        emit_last  = 1'b0;
        unit_load  = 1'b0;
        digit_wr   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode_reg)
                        MODE_ARG:
                        begin
                            if (in_req == REQ_ARG)
                            begin
                                mode_next  = MODE_PLAIN;
                                count_next = '0;
                                case (spec_reg)
                                    SPEC_D:
                                    begin
                                        if (in_arg[ARG_WIDTH-1])
                                        begin
                                            // Negate through the unsigned magnitude so
                                            // the most negative value prints correctly.
                                            work_next  = ~in_arg + 1'b1;
                                            state_next = S_SIGN;
                                        end
                                        else
                                        begin
                                            work_next  = in_arg;
                                            state_next = S_MUL;
                                        end
                                    end
                                    SPEC_U, SPEC_X:
                                    begin
                                        work_next  = in_arg;
                                        state_next = S_MUL;
                                    end
                                    default:
                                    begin
                                        char_next  = in_arg[7:0];
                                        pre_next   = (in_arg[7:0] == CHAR_NL);
                                        state_next = S_CHAR;
                                    end
                                endcase
                            end
                        end
                        MODE_PCT:
                        begin
                            if (in_req == REQ_FMT)
                            begin
                                mode_next = MODE_PLAIN;
                                pre_next  = 1'b0;
                                case (in_char)
                                    CHAR_LC_D:
                                    begin
                                        spec_next = SPEC_D;
                                        mode_next = MODE_ARG;
                                    end
                                    CHAR_LC_U:
                                    begin
                                        spec_next = SPEC_U;
                                        mode_next = MODE_ARG;
                                    end
                                    CHAR_LC_X, CHAR_UC_X:
                                    begin
                                        spec_next = SPEC_X;
                                        mode_next = MODE_ARG;
                                    end
                                    CHAR_LC_C:
                                    begin
                                        spec_next = SPEC_C;
                                        mode_next = MODE_ARG;
                                    end
                                    CHAR_LC_S:
                                    begin
                                        mode_next = MODE_PLAIN;
                                    end
                                    CHAR_PCT:
                                    begin
                                        char_next  = CHAR_PCT;
                                        state_next = S_CHAR;
                                    end
                                    default:
                                    begin
                                        char_next  = CHAR_QM;
                                        state_next = S_CHAR;
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                            if (in_req == REQ_FMT)
                            begin
                                mode_next = MODE_PLAIN;
                                if (in_char == CHAR_PCT)
                                begin
                                    mode_next = MODE_PCT;
                                end
                                else
                                begin
                                    char_next  = in_char;
                                    pre_next   = (in_char == CHAR_NL);
                                    state_next = S_CHAR;
                                end
                            end
                        end
                    endcase
                end
            end
            S_CHAR:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (pre_reg)
                    begin
                        emit_char = CHAR_CR;
                        pre_next  = 1'b0;
                    end
                    else
                    begin
                        emit_char  = char_reg;
                        emit_last  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_char  = CHAR_MINUS;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                unit_load  = 1'b1;
                state_next = S_DIG;
            end
            S_DIG:
            begin
                digit_wr   = 1'b1;
                work_next  = unit_quot;
                count_next = count_reg + 1'b1;
                if ((unit_quot == '0) || (count_reg == COUNT_W'(DIGIT_DEPTH - 1)))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_char  = digit_store[4'(count_reg - 1'b1)];
                    emit_last  = (count_reg == COUNT_W'(1));
                    count_next = count_reg - 1'b1;
                    if (count_reg == COUNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mode_reg    <= MODE_PLAIN;
            spec_reg    <= SPEC_D;
            work_reg    <= '0;
            count_reg   <= '0;
            pre_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            spec_reg  <= spec_next;
            work_reg  <= work_next;
            count_reg <= count_next;
            pre_reg   <= pre_next;
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        if (emit)
        begin
            m_data_reg <= emit_char;
            m_last_reg <= emit_last;
        end
        if (digit_wr)
        begin
            digit_store[4'(count_reg)] <= unit_char;
        end
    end

`ifndef NO_ASSERTIONS
    // Digits are only emitted while at least one remains in the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (count_reg != '0))
    else $error("digit emission with an empty digit store");

    // A digit step never writes beyond the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIG) |-> (count_reg < COUNT_W'(DIGIT_DEPTH)))
    else $error("digit store overflow");

    // An argument taken in its turn always leads to output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode_reg == MODE_ARG) && (in_req == REQ_ARG))
        |=> (state_reg != S_IDLE))
    else $error("argument accepted without producing output");

    // A finished item leaves the sequencer with its final character issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != S_IDLE) && (state_next == S_IDLE)) |-> (emit && emit_last))
    else $error("item finished without a final character");
`endif

endmodule

[src/fpe_digit_unit.sv]
// ============================================================================
// fpe_digit_unit - shared digit extraction unit
// Splits the least significant digit off a value, in base ten or sixteen.
// Operands are captured on load; quotient and digit are valid the cycle after.
// ============================================================================
module fpe_digit_unit
(
    input  logic                           clk,
    input  logic                           load,
    input  logic                           hex,
    input  logic [fpe_pkg::ARG_WIDTH-1:0]  value,
    output logic [fpe_pkg::ARG_WIDTH-1:0]  quot,
    output logic [7:0]                     digit_char
);
    import fpe_pkg::*;

    logic [ARG_WIDTH-1:0]   val_reg;
    logic                   hex_reg;
    logic [2*ARG_WIDTH-1:0] prod_reg;

    logic [ARG_WIDTH-1:0] dec_quot;
    logic [ARG_WIDTH-1:0] dec_rem;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg  <= value;
            hex_reg  <= hex;
            prod_reg <= {{ARG_WIDTH{1'b0}}, value} * {{ARG_WIDTH{1'b0}}, DIV10_RECIP};
        end
    end

    always_comb
    begin
        dec_quot = ARG_WIDTH'(prod_reg >> DIV10_SHIFT);
        // Remainder is the value less ten times the quotient.
        dec_rem  = val_reg - ((dec_quot << 3) + (dec_quot << 1));
        if (hex_reg)
        begin
            quot       = val_reg >> 4;
            digit_char = hex_char(val_reg[3:0]);
        end
        else
        begin
            quot       = dec_quot;
            digit_char = hex_char(dec_rem[3:0]);
        end
    end

endmodule

[tb/fpe_checker.sv]
// ============================================================================
// fpe_checker - scoreboard for the format print engine
// Watches both stream channels. Every accepted input transaction is run
// through a behavioural model of the formatter, and each output transaction
// is compared with the oldest character still awaited.
// ============================================================================
module fpe_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] fmt_char, [39:8] arg_word
    input  logic [0:0]  s_tuser,   // [0] req_type

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_char
    input  logic        m_tlast,   // last_char

    output int          mismatches,
    output int          outstanding
);
    import fpe_pkg::*;

    typedef struct packed
    {
        logic [7:0] glyph;
        logic       last;
    } text_char_t;

    text_char_t  awaited_text[$];
    logic [7:0]  line_glyphs[$];
    parse_mode_t fmt_state;
    spec_t       conv_kind;
    int          error_tally;

    // A newline always goes out as carriage return followed by newline.
    function automatic void stage_glyph(input logic [7:0] ch);
        if (ch == CHAR_NL)
        begin
            line_glyphs.push_back(CHAR_CR);
        end
        line_glyphs.push_back(ch);
    endfunction

    // Digits are produced least significant first and printed the other way.
    function automatic void stage_number(input logic [31:0] value, input logic radix16);
        logic [7:0]  digits[$];
        logic [31:0] rest;
        logic [3:0]  nib;
        rest = value;
        do
        begin
            if (radix16)
            begin
                nib  = rest[3:0];
                rest = rest >> 4;
            end
            else
            begin
                nib  = 4'(rest % 32'd10);
                rest = rest / 32'd10;
            end
            digits.push_front((nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h61 + 8'(nib) - 8'd10);
        end
        while (rest != 32'd0);
        foreach (digits[i])
        begin
            line_glyphs.push_back(digits[i]);
        end
    endfunction

    function automatic void format_expected_text(input logic req, input logic [7:0] ch,
                                                 input logic [31:0] arg);
        logic [31:0] magnitude;
        line_glyphs.delete();
        if (fmt_state == MODE_ARG)
        begin
            // Format bytes are dropped while an argument is awaited.
            if (req == REQ_ARG)
            begin
                fmt_state = MODE_PLAIN;
                case (conv_kind)
                    SPEC_D:
                    begin
                        if (arg[31])
                        begin
                            line_glyphs.push_back(CHAR_MINUS);
                            magnitude = ~arg + 32'd1;
                            stage_number(magnitude, 1'b0);
                        end
                        else
                        begin
                            stage_number(arg, 1'b0);
                        end
                    end
                    SPEC_U:  stage_number(arg, 1'b0);
                    SPEC_X:  stage_number(arg, 1'b1);
                    default: stage_glyph(arg[7:0]);
                endcase
            end
        end
        else if (req == REQ_FMT)
        begin
            if (fmt_state == MODE_PCT)
            begin
                fmt_state = MODE_PLAIN;
                case (ch)
                    CHAR_LC_D:
                    begin
                        conv_kind = SPEC_D;
                        fmt_state = MODE_ARG;
                    end
                    CHAR_LC_U:
                    begin
                        conv_kind = SPEC_U;
                        fmt_state = MODE_ARG;
                    end
                    CHAR_LC_X, CHAR_UC_X:
                    begin
                        conv_kind = SPEC_X;
                        fmt_state = MODE_ARG;
                    end
                    CHAR_LC_C:
                    begin
                        conv_kind = SPEC_C;
                        fmt_state = MODE_ARG;
                    end
                    CHAR_LC_S: ;
                    CHAR_PCT:  line_glyphs.push_back(CHAR_PCT);
                    default:   line_glyphs.push_back(CHAR_QM);
                endcase
            end
            else if (ch == CHAR_PCT)
            begin
                fmt_state = MODE_PCT;
            end
            else
            begin
                stage_glyph(ch);
            end
        end
        // Arguments out of turn give nothing.
        foreach (line_glyphs[i])
        begin
            awaited_text.push_back('{glyph: line_glyphs[i], last: (i == line_glyphs.size() - 1)});
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t head;
        if (!rst_n)
        begin
            awaited_text.delete();
            fmt_state   = MODE_PLAIN;
            conv_kind   = SPEC_D;
            error_tally = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                format_expected_text(s_tuser[0], s_tdata[7:0], s_tdata[39:8]);
            end
            if (m_tvalid && m_tready)
            begin
                if (awaited_text.size() == 0)
                begin
                    $display("%0t: unexpected output transaction, char 0x%02h last %0b",
                             $time, m_tdata, m_tlast);
                    error_tally++;
                end
                else
                begin
                    head = awaited_text.pop_front();
                    if (m_tdata !== head.glyph)
                    begin
                        $display("%0t: out_char mismatch, expected 0x%02h, actual 0x%02h",
                                 $time, head.glyph, m_tdata);
                        error_tally++;
                    end
                    if (m_tlast !== head.last)
                    begin
                        $display("%0t: last_char mismatch, expected %0b, actual %0b",
                                 $time, head.last, m_tlast);
                        error_tally++;
                    end
                end
            end
            mismatches  <= error_tally;
            outstanding <= awaited_text.size();
        end
    end

endmodule

[tb/tb_top.sv]
// ============================================================================
// tb_top - testbench for the format print engine
// Drives format characters and argument words into the block, with random
// gaps on both channels and one long output stall, and leaves all checking
// to the scoreboard beside the block.
// ============================================================================
module tb_top;
    import fpe_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [7:0] fmt_char, [39:8] arg_word
    logic [0:0]  s_tuser;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_char
    logic        m_tlast;   // last_char

    int          mismatches;
    int          outstanding;

    // Idle percentages of the sender and receiver, set by the current phase.
    int          phase;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          useful_items;

    format_print_engine u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    fpe_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("format_print_engine test failed");
        $finish;
    end

    // The receiver accepts at random according to the phase. When the
    // no-idle phase begins it holds off for a long stretch once, so that the
    // block fills up and has to stall its input while the sender keeps
    // offering transactions.
    initial
    begin
        int hold_cycles;
        bit held_once;
        held_once = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (phase == 2 && !held_once)
            begin
                held_once = 1'b1;
                m_tready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < 400; hold_cycles++)
                begin
                    @(posedge clk);
                end
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Offers one input transaction, idling first at the sender's rate, and
    // returns at the edge where it is accepted. The valid line is only
    // lowered when an idle cycle is actually taken, so back-to-back
    // transactions keep it high.
    task automatic send_item(input logic req, input logic [7:0] ch, input logic [31:0] arg);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {arg, ch};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    // Argument words weighted towards the awkward cases: zero, the sign
    // boundary, the most negative value, powers of ten and short values.
    function automatic logic [31:0] pick_arg();
        logic [31:0] value;
        case ($urandom_range(0, 6))
            0: value = $urandom;
            1: value = $urandom >> $urandom_range(0, 31);
            2: value = $urandom_range(0, 9);
            3: value = 32'd0 - $urandom_range(1, 1000);
            4:
            begin
                case ($urandom_range(0, 5))
                    0: value = 32'h0000_0000;
                    1: value = 32'h8000_0000;
                    2: value = 32'hFFFF_FFFF;
                    3: value = 32'h7FFF_FFFF;
                    4: value = 32'd999_999_999;
                    default: value = 32'd1_000_000_000;
                endcase
            end
            5:
            begin
                value = 32'd1;
                repeat ($urandom_range(0, 9))
                begin
                    value = value * 32'd10;
                end
                value = value + $urandom_range(0, 2) - 32'd1;
            end
            default: value = 32'd0 - ($urandom >> $urandom_range(0, 31));
        endcase
        return value;
    endfunction

    // One phrase of format text. Most phrases are well-formed conversions or
    // plain text; the rest are escapes, unknown specifiers and items sent
    // out of turn. The unused field of each transaction carries random bits.
    task automatic send_random_phrase();
        int          pick;
        logic [7:0]  ch;
        logic [7:0]  spec;
        logic [31:0] arg;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            ch = ($urandom_range(0, 9) == 0) ? CHAR_NL : 8'($urandom);
            send_item(REQ_FMT, ch, $urandom);
            useful_items++;
            if (ch == CHAR_PCT)
            begin
                send_item(REQ_FMT, CHAR_PCT, $urandom);
                useful_items++;
            end
        end
        else if (pick < 75)
        begin
            case ($urandom_range(0, 4))
                0: spec = CHAR_LC_D;
                1: spec = CHAR_LC_U;
                2: spec = CHAR_LC_X;
                3: spec = CHAR_UC_X;
                default: spec = CHAR_LC_C;
            endcase
            send_item(REQ_FMT, CHAR_PCT, $urandom);
            send_item(REQ_FMT, spec, $urandom);
            // Now and then a format byte sneaks in while the argument is due.
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(REQ_FMT, 8'($urandom), $urandom);
            end
            arg = pick_arg();
            if (spec == CHAR_LC_C && $urandom_range(0, 3) == 0)
            begin
                arg[7:0] = CHAR_NL;
            end
            send_item(REQ_ARG, 8'($urandom), arg);
            useful_items += 3;
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 2))
                0: ch = CHAR_PCT;
                1: ch = CHAR_LC_S;
                default: ch = 8'($urandom);
            endcase
            send_item(REQ_FMT, CHAR_PCT, $urandom);
            send_item(REQ_FMT, ch, $urandom);
            useful_items += 2;
        end
        else
        begin
            // An argument out of turn is simply dropped by the block.
            send_item(REQ_ARG, 8'($urandom), $urandom);
        end
    endtask

    initial
    begin
        phase        = 0;
        tx_idle_pct  = 23;
        rx_idle_pct  = 69;
        useful_items = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (12)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: field extremes, escapes and the corner cases of the
        // parser, with the sender and receiver idling as in the first phase.
        send_item(REQ_FMT, 8'h41, 32'h0000_0000);
        send_item(REQ_FMT, 8'h00, 32'hFFFF_FFFF);
        send_item(REQ_FMT, 8'hFF, 32'h0000_0000);
        send_item(REQ_FMT, CHAR_NL, 32'h5555_5555);
        send_item(REQ_FMT, CHAR_PCT, 32'h0);
        send_item(REQ_FMT, CHAR_PCT, 32'h0);
        send_item(REQ_FMT, CHAR_PCT, 32'h0);
        send_item(REQ_FMT, CHAR_LC_S, 32'h0);
        // A NUL byte after the percent sign is an unknown specifier.
        send_item(REQ_FMT, CHAR_PCT, 32'h0);
        send_item(REQ_FMT, 8'h00, 32'h0);
        send_item(REQ_ARG, 8'hFF, 32'h1234_5678);
        send_item(REQ_FMT, CHAR_PCT, 32'h0);
        send_item(REQ_FMT, CHAR_LC_D, 32'h0);
        send_item(REQ_ARG, 8'h00, 32'h8000_0000);
        // A format byte while the argument is due must be ignored.
        send_item(REQ_FMT, CHAR_PCT, 32'h0);
        send_item(REQ_FMT, CHAR_LC_D, 32'h0);
        send_item(REQ_FMT, 8'h7A, 32'h0);
        send_item(REQ_ARG, 8'hAA, 32'hFFFF_FFFF);
        send_item(REQ_FMT, CHAR_PCT, 32'h0);
        send_item(REQ_FMT, CHAR_LC_U, 32'h0);
        send_item(REQ_ARG, 8'h00, 32'h0000_0000);
        send_item(REQ_FMT, CHAR_PCT, 32'h0);
        send_item(REQ_FMT, CHAR_UC_X, 32'h0);
        send_item(REQ_ARG, 8'h00, 32'hFFFF_FFFF);
        send_item(REQ_FMT, CHAR_PCT, 32'h0);
        send_item(REQ_FMT, CHAR_LC_C, 32'h0);
        send_item(REQ_ARG, 8'h00, 32'hABCD_EF0A);

        // Random part in three phases: the sender idling lightly and the
        // receiver heavily, then the other way round, then neither.
        useful_items = 0;
        while (useful_items < 450)
        begin
            if (phase == 0 && useful_items >= 150)
            begin
                phase       = 1;
                tx_idle_pct = 69;
                rx_idle_pct = 23;
            end
            else if (phase == 1 && useful_items >= 300)
            begin
                phase       = 2;
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_random_phrase();
        end
        s_tvalid <= 1'b0;

        // Let the scoreboard see the last transaction before draining, then
        // give the block time to finish an item that produces nothing.
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (40)
        begin
            @(posedge clk);
        end

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("format_print_engine test passed");
        end
        else
        begin
            $display("format_print_engine test failed");
        end
        $finish;
    end

endmodule
